FILE: design/pink_noise_filter_top_defines.svh
// Assertion macros shared by the pink noise filter modules.
// Needs signals named clock and reset in the module that uses them.
`ifndef PINK_NOISE_FILTER_TOP_DEFINES_SVH
`define PINK_NOISE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PNF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pink noise filter check failed");

// next-cycle implication
`define PNF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pink noise filter check failed");

`else

`define PNF_ASSERT_IMP(lbl, ante, cons)
`define PNF_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: design/pnf_pkg.sv
// Package for the pink noise filter: widths, coefficients, operation codes
// and the status structs passed between modules. No dependencies.
`default_nettype none

package pnf_pkg;

   localparam int PNF_STATE_WIDTH  = 32;
   localparam int PNF_SAMPLE_WIDTH = 16;
   localparam int PNF_COEF_WIDTH   = 18;
   localparam int PNF_COEF_FRAC    = 17;
   localparam int PNF_AMP_WIDTH    = 16;
   localparam int PNF_AMP_FRAC     = 12;
   localparam int PNF_NUM_POLES    = 6;
   localparam int PNF_OP_WIDTH     = 4;

   localparam logic [PNF_AMP_WIDTH-1:0] PNF_AMP_RESET = 16'd4096;

   // operation codes; codes below PNF_OP_DIRECT are the pole sections,
   // even = state times pole, odd = white times feed
   localparam logic [PNF_OP_WIDTH-1:0] PNF_OP_DIRECT = 4'd12;
   localparam logic [PNF_OP_WIDTH-1:0] PNF_OP_TAP    = 4'd13;
   localparam logic [PNF_OP_WIDTH-1:0] PNF_OP_NORM   = 4'd14;
   localparam logic [PNF_OP_WIDTH-1:0] PNF_OP_AMP    = 4'd15;

   typedef logic signed [PNF_COEF_WIDTH-1:0] pnf_coef_type;

   localparam pnf_coef_type PNF_POLE_GAIN [PNF_NUM_POLES] = '{
      18'sd130923, 18'sd130196, 18'sd127009, 18'sd113574, 18'sd72090, -18'sd99824
   };
   localparam pnf_coef_type PNF_POLE_FEED [PNF_NUM_POLES] = '{
      18'sd7277, 18'sd9840, 18'sd20166, 18'sd40696, 18'sd69855, -18'sd2215
   };
   localparam pnf_coef_type PNF_DIRECT_COEF = 18'sd70281;
   localparam pnf_coef_type PNF_TAP_COEF    = 18'sd15195;
   localparam pnf_coef_type PNF_NORM_COEF   = 18'sd14418;

   typedef struct packed {
      logic busy;
      logic last;
   } pnf_mul_stat_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } pnf_core_stat_type;

   // fixed coefficient for an operation; the amplitude step is handled outside
   function automatic pnf_coef_type pnf_coef(input logic [PNF_OP_WIDTH-1:0] op);
      pnf_coef_type c;
      c = '0;
      if (op < PNF_OP_DIRECT) begin
         c = op[0] ? PNF_POLE_FEED[op[3:1]] : PNF_POLE_GAIN[op[3:1]];
      end else begin
         case (op)
            PNF_OP_DIRECT: c = PNF_DIRECT_COEF;
            PNF_OP_TAP:    c = PNF_TAP_COEF;
            PNF_OP_NORM:   c = PNF_NORM_COEF;
            default:       c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/pnf_serial_mult.sv
// Bit-serial signed multiplier: one coefficient bit per cycle, product
// collected in a single shift register. Uses pnf_pkg and the assertion macros.
`default_nettype none
`include "pink_noise_filter_top_defines.svh"

module pnf_serial_mult import pnf_pkg::*; #(
   parameter int MCAND_WIDTH = PNF_STATE_WIDTH + 3
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         start,
   input  wire logic signed [MCAND_WIDTH-1:0]                mcand,
   input  wire pnf_coef_type                                 coef,
   output pnf_mul_stat_type                                  stat,
   output logic signed [MCAND_WIDTH+PNF_COEF_WIDTH:0]        product
);

   localparam int ProdWidth = MCAND_WIDTH + PNF_COEF_WIDTH + 1;
   localparam int CntWidth  = $clog2(PNF_COEF_WIDTH);

   logic [ProdWidth-1:0]            p_ff, p_in;
   logic signed [MCAND_WIDTH-1:0]   m_ff, m_in;
   logic [CntWidth-1:0]             cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;

   logic                            last_step;
   logic signed [MCAND_WIDTH:0]     high_part;
   logic signed [MCAND_WIDTH:0]     m_ext;
   logic signed [MCAND_WIDTH:0]     addend;
   logic signed [MCAND_WIDTH:0]     sum;

   assign last_step = busy_ff && (cnt_ff == CntWidth'(PNF_COEF_WIDTH - 1));
   assign high_part = $signed(p_ff[ProdWidth-1:PNF_COEF_WIDTH]);
   assign m_ext     = {m_ff[MCAND_WIDTH-1], m_ff};
   // sign bit of the coefficient weighs negative
   assign addend    = p_ff[0] ? (last_step ? -m_ext : m_ext) : '0;
   assign sum       = high_part + addend;

   always_comb begin
      p_in    = p_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         p_in    = {{(MCAND_WIDTH + 1){1'b0}}, coef};
         m_in    = mcand;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {sum[MCAND_WIDTH], sum, p_ff[PNF_COEF_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      p_ff <= p_in;
      m_ff <= m_in;
   end

   assign stat.busy = busy_ff;
   assign stat.last = last_step;
   assign product   = $signed(p_ff);

   `PNF_ASSERT_IMP(a_start_when_free, start, !busy_ff)
   `PNF_ASSERT_NXT(a_last_frees_unit, last_step, !busy_ff)

endmodule

`default_nettype wire

FILE: design/pnf_core.sv
// Filter sequencer: section states, tap, accumulator and the sixteen
// products per item run through pnf_serial_mult. Uses pnf_pkg.
`default_nettype none
`include "pink_noise_filter_top_defines.svh"

module pnf_core import pnf_pkg::*; #(
   parameter int STATE_WIDTH  = PNF_STATE_WIDTH,
   parameter int SAMPLE_WIDTH = PNF_SAMPLE_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    white,
   input  wire logic [PNF_AMP_WIDTH-1:0]          amplitude,
   input  wire logic                              out_free,
   output pnf_core_stat_type                      stat,
   output logic signed [SAMPLE_WIDTH-1:0]         pink
);

   localparam int AccWidth   = STATE_WIDTH + 3;
   localparam int ProdWidth  = AccWidth + PNF_COEF_WIDTH + 1;
   localparam int YWidth     = AccWidth + 8;
   localparam int StateFrac  = STATE_WIDTH - 5;
   localparam int WhtShift   = SAMPLE_WIDTH - 1 + PNF_COEF_FRAC - StateFrac;
   localparam int WhtShiftR  = (WhtShift > 0) ? WhtShift : 0;
   localparam int WhtShiftL  = (WhtShift < 0) ? -WhtShift : 0;
   localparam int OutShift   = StateFrac - (SAMPLE_WIDTH - 1);
   localparam int OutShiftR  = (OutShift > 0) ? OutShift : 0;
   localparam int OutShiftL  = (OutShift < 0) ? -OutShift : 0;
   localparam int SampMax    = (1 << (SAMPLE_WIDTH - 1)) - 1;
   localparam int SampMin    = -SampMax - 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_RUN  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [PNF_OP_WIDTH-1:0]          op_ff, op_in;
   logic signed [SAMPLE_WIDTH-1:0]   w_ff, w_in;
   logic signed [AccWidth-1:0]       acc_ff, acc_in;
   logic signed [AccWidth-1:0]       mid_ff, mid_in;
   logic signed [STATE_WIDTH-1:0]    tap_ff, tap_in;
   logic signed [STATE_WIDTH-1:0]    pole_ff [PNF_NUM_POLES];
   logic signed [STATE_WIDTH-1:0]    pole_in [PNF_NUM_POLES];

   logic [2:0]                       pole_idx;
   logic                             mul_start;
   logic signed [AccWidth-1:0]       mul_mcand;
   pnf_coef_type                     mul_coef;
   pnf_mul_stat_type                 mul_stat;
   logic signed [ProdWidth-1:0]      prod;

   logic signed [ProdWidth-1:0]      prod_coef;
   logic signed [ProdWidth-1:0]      prod_wht;
   logic signed [ProdWidth-1:0]      prod_amp;
   logic signed [STATE_WIDTH-1:0]    t_pole;
   logic signed [STATE_WIDTH-1:0]    t_wht;
   logic signed [AccWidth-1:0]       t_norm;
   logic signed [STATE_WIDTH:0]      pole_sum;
   logic signed [STATE_WIDTH-1:0]    pole_sat;
   logic signed [YWidth-1:0]         y_amp;
   logic signed [YWidth-1:0]         y_out;
   logic                             res_valid;

   assign pole_idx = op_ff[3:1];

   pnf_serial_mult #(
      .MCAND_WIDTH (AccWidth)
   ) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .coef    (mul_coef),
      .stat    (mul_stat),
      .product (prod)
   );

   // operand selection for the current operation
   always_comb begin
      if (op_ff < PNF_OP_DIRECT && !op_ff[0]) begin
         mul_mcand = AccWidth'(pole_ff[pole_idx]);
      end else if (op_ff == PNF_OP_NORM) begin
         mul_mcand = acc_ff;
      end else if (op_ff == PNF_OP_AMP) begin
         mul_mcand = mid_ff;
      end else begin
         mul_mcand = AccWidth'(w_ff);
      end
      mul_coef = (op_ff == PNF_OP_AMP) ? $signed(PNF_COEF_WIDTH'(amplitude))
                                       : pnf_coef(op_ff);
   end

   // product scaling; all shifts truncate toward minus infinity
   assign prod_coef = prod >>> PNF_COEF_FRAC;
   assign prod_wht  = (WhtShift >= 0) ? (prod >>> WhtShiftR) : (prod <<< WhtShiftL);
   assign prod_amp  = prod >>> PNF_AMP_FRAC;
   assign t_pole    = $signed(prod_coef[STATE_WIDTH-1:0]);
   assign t_wht     = $signed(prod_wht[STATE_WIDTH-1:0]);
   assign t_norm    = $signed(prod_coef[AccWidth-1:0]);

   assign pole_sum  = $signed({mid_ff[STATE_WIDTH-1], mid_ff[STATE_WIDTH-1:0]})
                      + $signed({t_wht[STATE_WIDTH-1], t_wht});
   assign pole_sat  = (pole_sum[STATE_WIDTH] != pole_sum[STATE_WIDTH-1])
                      ? {pole_sum[STATE_WIDTH], {(STATE_WIDTH-1){~pole_sum[STATE_WIDTH]}}}
                      : pole_sum[STATE_WIDTH-1:0];

   assign y_amp = $signed(prod_amp[YWidth-1:0]);
   assign y_out = (OutShift >= 0) ? (y_amp >>> OutShiftR) : (y_amp <<< OutShiftL);

   always_comb begin
      if (y_out > $signed(YWidth'(SampMax))) begin
         pink = $signed(SAMPLE_WIDTH'(SampMax));
      end else if (y_out < $signed(YWidth'(SampMin))) begin
         pink = $signed(SAMPLE_WIDTH'(SampMin));
      end else begin
         pink = y_out[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      w_in      = w_ff;
      acc_in    = acc_ff;
      mid_in    = mid_ff;
      tap_in    = tap_ff;
      pole_in   = pole_ff;
      mul_start = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               w_in     = white;
               acc_in   = AccWidth'(tap_ff);
               op_in    = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_start = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (mul_stat.last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (op_ff < PNF_OP_DIRECT) begin
               if (!op_ff[0]) begin
                  mid_in = AccWidth'(t_pole);
               end else begin
                  pole_in[pole_idx] = pole_sat;
                  acc_in            = acc_ff + AccWidth'(pole_sat);
               end
            end else begin
               case (op_ff)
                  PNF_OP_DIRECT: acc_in = acc_ff + AccWidth'(t_wht);
                  PNF_OP_TAP:    tap_in = t_wht;
                  PNF_OP_NORM:   mid_in = t_norm;
                  default:       mid_in = mid_ff;
               endcase
            end
            if (op_ff == PNF_OP_AMP) begin
               state_in = ST_FIN;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= '0;
         tap_ff   <= '0;
         for (int i = 0; i < PNF_NUM_POLES; i++) begin
            pole_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         tap_ff   <= tap_in;
         pole_ff  <= pole_in;
      end
      w_ff   <= w_in;
      acc_ff <= acc_in;
      mid_ff <= mid_in;
   end

   assign stat.idle      = (state_ff == ST_IDLE);
   assign stat.res_valid = res_valid;

   `PNF_ASSERT_IMP(a_accept_only_idle, start, state_ff == ST_IDLE)
   `PNF_ASSERT_IMP(a_result_has_room, res_valid, out_free)
   `PNF_ASSERT_IMP(a_run_keeps_mult_busy, state_ff == ST_RUN, mul_stat.busy)

endmodule

`default_nettype wire

FILE: design/pink_noise_filter_top.sv
// Pink noise filter top level: stream channels, amplitude register and
// output register around pnf_core. Uses pnf_pkg, pnf_core, pnf_serial_mult.
//
// Usage:
//   req_*  : one white sample per item (signed Q1.15 in tdata), tlast marks
//            the last sample of a block.
//   rsp_*  : one pink sample per item (signed Q1.15 in tdata), tlast copied.
//   csr_*  : write of the amplitude gain, unsigned Q4.12, 4096 = unity;
//            always ready, write it only while the filter is idle.
// Each item runs 16 products through one bit-serial multiplier, each in
// the load, a step for each coefficient bit, and the update; the result is
// then handed to the output register, which drives rsp_tvalid.
// A new item is accepted only once the previous one has moved to the output
// register, so items are not overlapped.
// If the receiver stalls, the result waits in the output register while the
// next item is computed; that item then holds until the register frees.
// Reset (synchronous, active high) clears all section states, the tap, the
// handshakes and sets the gain to unity.
`default_nettype none

module pink_noise_filter_top import pnf_pkg::*; #(
   parameter int STATE_WIDTH  = PNF_STATE_WIDTH,
   parameter int SAMPLE_WIDTH = PNF_SAMPLE_WIDTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // [SAMPLE_WIDTH-1:0] white_sample, rest zero
   input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [SAMPLE_WIDTH-1:0] pink_sample, rest zero
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0]      rsp_tdata,
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [PNF_AMP_WIDTH-1:0]               csr_data
);

   localparam int DataWidth = ((SAMPLE_WIDTH + 7) / 8) * 8;

   logic [PNF_AMP_WIDTH-1:0]        amp_ff, amp_in;
   logic                            eob_ff, eob_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]         rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   pnf_core_stat_type               core_stat;
   logic signed [SAMPLE_WIDTH-1:0]  core_pink;
   logic                            req_accept;
   logic                            out_free;

   assign req_tready = core_stat.idle;
   assign req_accept = req_tvalid && core_stat.idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   pnf_core #(
      .STATE_WIDTH  (STATE_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .white     ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .amplitude (amp_ff),
      .out_free  (out_free),
      .stat      (core_stat),
      .pink      (core_pink)
   );

   always_comb begin
      amp_in       = amp_ff;
      eob_in       = eob_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (csr_valid) begin
         amp_in = csr_data;
      end
      if (req_accept) begin
         eob_in = req_tlast;
      end
      if (core_stat.res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_pink;
         rsp_last_in  = eob_ff;
      end else if (rsp_tready) begin
         // drop the item once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff       <= PNF_AMP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         amp_ff       <= amp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eob_ff      <= eob_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DataWidth'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
